>>> rtl/core/fmm_pkg.sv
// Package for the field motion mask combiner.
// Holds sizes, register indexes, class and value tables, and the cell bus type.
// No dependencies.
package fmm_pkg;

    localparam int LENGTH  = 10;
    localparam int CCOUNT  = 2 * ((LENGTH - 2) / 2);
    localparam int OCOUNT  = 2 * ((LENGTH - 1) / 2) - 1;
    localparam int CMID    = CCOUNT / 2;
    localparam int WIN     = LENGTH - 4;
    localparam int OPP_OFF = (LENGTH % 2 == 1) ? 0 : 1;
    localparam int CUR_OFF = 1 - OPP_OFF;

    localparam int CUR_W  = 8;
    localparam int OPP_W  = 7;
    localparam int CUR_N  = (CCOUNT < CUR_W) ? CCOUNT : CUR_W;
    localparam int OPP_N  = (OCOUNT < OPP_W) ? OCOUNT : OPP_W;
    localparam int SLOT_W = 2 * LENGTH - 5;
    localparam int IDX_W  = $clog2(LENGTH);
    localparam int CODE_W = 6;
    localparam int VAL_W  = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_ORDER = 2'd1;

    localparam logic [1:0] MT_RESET = 2'd1;
    localparam logic [1:0] MT_MAX   = 2'd2;
    localparam logic [1:0] CLS_STOP = 2'd2;

    localparam logic [VAL_W-1:0] VAL_STATIC = 6'd60;

    localparam logic [SLOT_W-1:0] WIN_MASK = SLOT_W'((64'd1 << WIN) - 64'd1);

    typedef logic [SLOT_W-1:0] t_slots;

    typedef struct packed {
        logic              valid;
        logic              parity;
        logic              early;
        logic              done;
        logic [CODE_W-1:0] code;
        t_slots            above;
        t_slots            below;
    } t_cell_bus;

    localparam logic [1:0] CLASS_TAB [3][64] = '{
        '{2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0, 2'd2, 2'd2,
          2'd1, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd3, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2,
          2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
        '{2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2,
          2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2,
          2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
          2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
          2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1,
          2'd0, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2,
          2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd2,
          2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd3, 2'd3,
          2'd0, 2'd1, 2'd0, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1,
          2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2,
          2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2}
    };

    localparam logic [VAL_W-1:0] VALUE_TAB [2][8] = '{
        '{6'd60, 6'd20, 6'd50, 6'd10, 6'd60, 6'd10, 6'd40, 6'd30},
        '{6'd60, 6'd10, 6'd40, 6'd30, 6'd60, 6'd20, 6'd50, 6'd10}
    };

    function automatic logic [1:0] class_of(logic [1:0] mt, logic [CODE_W-1:0] code);
        logic [1:0] sel;
        sel = (mt > MT_MAX) ? MT_MAX : mt;
        return CLASS_TAB[sel][code];
    endfunction

    function automatic t_slots interleave(logic [CUR_W-1:0] cur, logic [OPP_W-1:0] opp);
        t_slots s;
        s = '0;
        for (int k = 0; k < CUR_N; k++) begin
            s[2 * k + CUR_OFF] = cur[k];
        end
        for (int k = 0; k < OPP_N; k++) begin
            s[2 * k + OPP_OFF] = opp[k];
        end
        return s;
    endfunction

endpackage

>>> rtl/core/fmm_cell.sv
// One scan cell: tests the window that starts at its own slot and updates the code.
// Depends on fmm_pkg.
module fmm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [fmm_pkg::IDX_W-1:0] i_idx,
    input  logic [1:0]                i_match_type,
    input  fmm_pkg::t_cell_bus        i_bus,
    output fmm_pkg::t_cell_bus        o_bus
);
    import fmm_pkg::*;

    t_cell_bus         r_bus;
    t_cell_bus         n_bus;
    t_slots            win;
    logic              hit_a;
    logic              hit_b;
    logic [2:0]        weight;
    logic [CODE_W-1:0] code_upd;

    always_comb begin
        win   = WIN_MASK << i_idx;
        hit_a = (i_bus.above & win) == win;
        hit_b = (i_bus.below & win) == win;
        priority if (i_idx == '0) begin
            weight = 3'd1;
        end else if (i_idx == IDX_W'(LENGTH - 1)) begin
            weight = 3'd4;
        end else begin
            weight = 3'd2;
        end
        code_upd = i_bus.code | (hit_a ? {weight, 3'd0} : '0) | (hit_b ? {3'd0, weight} : '0);
        n_bus = i_bus;
        if (!i_bus.early && !i_bus.done) begin
            n_bus.code = code_upd;
            n_bus.done = class_of(i_match_type, code_upd) == CLS_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

>>> rtl/core/field_motion_mask_combiner.sv
// Top level of the field motion mask combiner: config registers, cell chain, output stage.
// Depends on fmm_pkg and fmm_cell.
//
// Usage:
//   Input: an item transfers at a clock edge with i_start high and o_busy low.
//   o_busy is always low, so one item may be started every cycle.
//   Output: o_mask_strobe marks o_mask_value for exactly one cycle; the
//   receiver cannot stall, and none is needed since nothing backs up.
//   Config: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 is match_type (values above 2 act as 2), index 1 is field_order.
//   o_cfg_ready is always high. Write only when no item is in flight.
// Timing:
//   Each item passes through one register per cell of the scan chain,
//   one cell per window start, then the output register. Throughput is one item
//   per cycle; the chain of scan cells is fully pipelined.
// Reset:
//   Synchronous active-low reset clears the chain and output strobe and sets
//   match_type to 1 and field_order to 0. Items in flight are dropped.
module field_motion_mask_combiner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_field_parity,
    input  logic [7:0]                     i_current_nonzero,
    input  logic [6:0]                     i_opposite_above,
    input  logic [6:0]                     i_opposite_below,
    output logic                           o_mask_strobe,
    output logic [5:0]                     o_mask_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fmm_pkg::*;

    logic [1:0]       r_match_type;
    logic             r_field_order;
    logic             r_strobe;
    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    t_cell_bus        head;
    t_cell_bus        chain [LENGTH+1];
    t_cell_bus        tail;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_type  <= MT_RESET;
            r_field_order <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MATCH_TYPE) begin
                r_match_type <= (i_cfg_data > MT_MAX) ? MT_MAX : i_cfg_data;
            end else if (i_cfg_index == REG_FIELD_ORDER) begin
                r_field_order <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        head        = '0;
        head.valid  = i_start && !o_busy;
        head.parity = i_field_parity;
        head.early  = !i_current_nonzero[CMID-2] && !i_current_nonzero[CMID]
                      && !i_current_nonzero[CMID+1];
        head.above  = interleave(i_current_nonzero, i_opposite_above);
        head.below  = interleave(i_current_nonzero, i_opposite_below);
    end

    assign chain[0] = head;

    for (genvar g = 0; g < LENGTH; g++) begin : g_cell
        fmm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_idx        (IDX_W'(g)),
            .i_match_type (r_match_type),
            .i_bus        (chain[g]),
            .o_bus        (chain[g+1])
        );
    end

    assign tail = chain[LENGTH];

    always_comb begin
        if (tail.early) begin
            n_value = VAL_STATIC;
        end else begin
            n_value = VALUE_TAB[r_field_order][{tail.parity, class_of(r_match_type, tail.code)}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_mask_strobe = r_strobe;
    assign o_mask_value  = r_value;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(LENGTH+1) o_mask_strobe)
        else $error("accepted item produced no result at fixed latency");

    a_value_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mask_strobe |-> (o_mask_value == 6'd10 || o_mask_value == 6'd20
            || o_mask_value == 6'd30 || o_mask_value == 6'd40
            || o_mask_value == 6'd50 || o_mask_value == 6'd60))
        else $error("mask value outside legal set");

    a_stop_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && tail.done) |-> (class_of(r_match_type, tail.code) == CLS_STOP))
        else $error("scan stopped on a code whose class is not stop");

    a_early_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && tail.early) |-> (tail.code == '0 && !tail.done))
        else $error("early-exit item had its code updated");
`endif

endmodule
